// ----- sv/assert_macros.svh -----
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, always on
`define ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/fpa_pkg.sv -----
package fpa_pkg;

    typedef logic [3:0] t_op;

    localparam t_op OP_ADD = 4'd0;
    localparam t_op OP_SUB = 4'd1;
    localparam t_op OP_MUL = 4'd2;
    localparam t_op OP_DIV = 4'd3;
    localparam t_op OP_GT  = 4'd4;
    localparam t_op OP_LT  = 4'd5;
    localparam t_op OP_GE  = 4'd6;
    localparam t_op OP_LE  = 4'd7;
    localparam t_op OP_EQ  = 4'd8;
    localparam t_op OP_NE  = 4'd9;
    localparam t_op OP_MIN = 4'd10;
    localparam t_op OP_MAX = 4'd11;
    localparam t_op OP_INC = 4'd12;
    localparam t_op OP_DEC = 4'd13;
    localparam t_op OP_I2F = 4'd14;
    localparam t_op OP_F2I = 4'd15;

    localparam int DATA_W = 32;

    // Control that travels down the divider stages
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              neg;
        logic              dz;
        logic              cmp;
        logic [DATA_W-1:0] result;
    } t_ctl;

endpackage

// ----- sv/fpa_if.sv -----
interface fpa_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, opcode, operand_a, operand_b, input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_value;
    logic        compare_true;
    logic        divide_by_zero;

    modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
    modport sink   (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface

// ----- sv/fpa_div_step.sv -----
module fpa_div_step #(
    parameter int NUM_W = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  fpa_pkg::t_ctl         i_ctl,
    input  logic [31:0]           i_rem,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [31:0]           i_den,
    input  logic [31:0]           i_quo,
    output fpa_pkg::t_ctl         o_ctl,
    output logic [31:0]           o_rem,
    output logic [NUM_W-1:0]      o_num,
    output logic [31:0]           o_den,
    output logic [31:0]           o_quo
);
    import fpa_pkg::*;

    t_ctl             r_ctl;
    logic [31:0]      r_rem, r_den, r_quo;
    logic [NUM_W-1:0] r_num;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             ge;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        trial = {i_rem, i_num[NUM_W-1]};
        diff  = trial - {1'b0, i_den};
        ge    = (trial >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.is_div <= i_ctl.is_div;
            r_ctl.neg    <= i_ctl.neg;
            r_ctl.dz     <= i_ctl.dz;
            r_ctl.cmp    <= i_ctl.cmp;
            r_ctl.result <= i_ctl.result;
            r_rem        <= ge ? diff[31:0] : trial[31:0];
            r_num        <= {i_num[NUM_W-2:0], 1'b0};
            r_den        <= i_den;
            r_quo        <= {i_quo[30:0], ge};
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;
    assign o_quo = r_quo;
endmodule

// ----- sv/fixed_point_alu_q24_8_top.sv -----
// Signed 32-bit fixed-point ALU with FRAC_BITS fractional bits. One word in gives one word
// out; a new word is taken every cycle unless back-pressure stalls the whole pipe in place,
// and results leave in order through the input register, stage 1, stage 2, the divider and
// the output register. The divider is a restoring one with one quotient bit per pipeline
// stage over 32+FRAC_BITS stages; every opcode takes the same path so order is kept.
`include "assert_macros.svh"

module fixed_point_alu_q24_8_top #(
    parameter int FRAC_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out
);
    import fpa_pkg::*;

    localparam int NUM_W = 32 + FRAC_BITS;

    logic en;

    // stage 0: input register
    logic               r0_valid;
    t_op                r0_op;
    logic signed [31:0] r0_a, r0_b;

    // stage 1: product, simple ops, divider prep
    logic               r1_valid;
    t_op                r1_op;
    logic signed [63:0] r1_prod;
    logic [31:0]        r1_res;
    logic               r1_cmp;
    logic [31:0]        r1_absa, r1_absb;
    logic               r1_neg, r1_bz;
    logic [31:0]        n1_res;
    logic               n1_cmp;

    // stage 2: control into divider
    t_ctl               r2_ctl;
    logic [31:0]        r2_absa, r2_absb;

    // divider chain
    t_ctl               ch_ctl [0:NUM_W];
    logic [31:0]        ch_rem [0:NUM_W];
    logic [NUM_W-1:0]   ch_num [0:NUM_W];
    logic [31:0]        ch_den [0:NUM_W];
    logic [31:0]        ch_quo [0:NUM_W];

    // output register
    logic               r_out_valid;
    logic [31:0]        r_out_res;
    logic               r_out_cmp, r_out_dz;
    t_ctl               last;
    logic [31:0]        n_out_res;

    assign en         = !r_out_valid || o_out.ready;
    // no word is taken while in reset
    assign i_in.ready = en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= i_in.valid;
        end
        if (en) begin
            r0_op <= i_in.opcode;
            r0_a  <= i_in.operand_a;
            r0_b  <= i_in.operand_b;
        end
    end

    always_comb begin
        n1_res = '0;
        n1_cmp = 1'b0;
        case (r0_op)
            OP_ADD: n1_res = r0_a + r0_b;
            OP_SUB: n1_res = r0_a - r0_b;
            OP_GT:  n1_cmp = (r0_a > r0_b);
            OP_LT:  n1_cmp = (r0_a < r0_b);
            OP_GE:  n1_cmp = (r0_a >= r0_b);
            OP_LE:  n1_cmp = (r0_a <= r0_b);
            OP_EQ:  n1_cmp = (r0_a == r0_b);
            OP_NE:  n1_cmp = (r0_a != r0_b);
            OP_MIN: n1_res = (r0_a < r0_b) ? r0_a : r0_b;
            OP_MAX: n1_res = (r0_a > r0_b) ? r0_a : r0_b;
            OP_INC: n1_res = r0_a + 32'sd1;
            OP_DEC: n1_res = r0_a - 32'sd1;
            OP_I2F: n1_res = r0_a <<< FRAC_BITS;
            OP_F2I: n1_res = r0_a >>> FRAC_BITS;
            default: n1_res = '0; // mul and div filled in later
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= r0_valid;
        end
        if (en) begin
            r1_op   <= r0_op;
            r1_prod <= 64'(r0_a) * 64'(r0_b);
            r1_res  <= n1_res;
            r1_cmp  <= n1_cmp;
            r1_absa <= r0_a[31] ? 32'(-r0_a) : r0_a;
            r1_absb <= r0_b[31] ? 32'(-r0_b) : r0_b;
            r1_neg  <= r0_a[31] ^ r0_b[31];
            r1_bz   <= (r0_b == 32'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl.valid <= 1'b0;
        end else if (en) begin
            r2_ctl.valid <= r1_valid;
        end
        if (en) begin
            r2_ctl.is_div <= (r1_op == OP_DIV);
            r2_ctl.neg    <= r1_neg;
            r2_ctl.dz     <= (r1_op == OP_DIV) && r1_bz;
            r2_ctl.cmp    <= r1_cmp;
            r2_ctl.result <= (r1_op == OP_MUL) ? r1_prod[FRAC_BITS+31:FRAC_BITS] : r1_res;
            r2_absa       <= r1_absa;
            r2_absb       <= r1_absb;
        end
    end

    assign ch_ctl[0] = r2_ctl;
    assign ch_rem[0] = '0;
    assign ch_num[0] = {r2_absa, {FRAC_BITS{1'b0}}};
    assign ch_den[0] = r2_absb;
    assign ch_quo[0] = '0;

    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        fpa_div_step #(.NUM_W(NUM_W)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ch_ctl[g]),
            .i_rem   (ch_rem[g]),
            .i_num   (ch_num[g]),
            .i_den   (ch_den[g]),
            .i_quo   (ch_quo[g]),
            .o_ctl   (ch_ctl[g+1]),
            .o_rem   (ch_rem[g+1]),
            .o_num   (ch_num[g+1]),
            .o_den   (ch_den[g+1]),
            .o_quo   (ch_quo[g+1])
        );
    end

    assign last = ch_ctl[NUM_W];

    always_comb begin
        if (!last.is_div) begin
            n_out_res = last.result;
        end else if (last.dz) begin
            n_out_res = '0;
        end else if (last.neg) begin
            n_out_res = -ch_quo[NUM_W];
        end else begin
            n_out_res = ch_quo[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
        if (en) begin
            r_out_res <= n_out_res;
            r_out_cmp <= last.cmp;
            r_out_dz  <= last.dz;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_value   = r_out_res;
    assign o_out.compare_true   = r_out_cmp;
    assign o_out.divide_by_zero = r_out_dz;

    `ASSERT_IMPL(a_dz_zero, i_clk, i_rst_n, r_out_valid && r_out_dz, r_out_res == '0 && !r_out_cmp)
    `ASSERT_IMPL(a_cmp_zero, i_clk, i_rst_n, r_out_valid && r_out_cmp, r_out_res == '0)
    `ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_out.valid)
endmodule

// ----- tb/fixed_point_alu_q24_8_top_tb.sv -----
module fixed_point_alu_q24_8_top_tb;
    import fpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 8;
    localparam int LATENCY = FRAC + 36;

    typedef struct packed {
        logic signed [31:0] value;
        logic               cmp;
        logic               dz;
    } t_alu_res;

    logic i_clk;
    logic i_rst_n;

    fpa_in_if  in_if();
    fpa_out_if out_if();

    fixed_point_alu_q24_8_top #(.FRAC_BITS(FRAC)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_alu_res expected_q[$];
    int       error_count;
    int       result_count;
    int       op_seen[16];
    bit       hold_off;
    int       hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAIL fixed_point_alu_q24_8_top");
        $finish;
    end

    // arithmetic right shift of a 64-bit value, kept to 32 bits
    function automatic logic [31:0] shr_wrap(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v >>> FRAC;
        return s[31:0];
    endfunction

    function automatic t_alu_res alu_predict(input t_op op, input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        t_alu_res r;
        logic signed [63:0] wa, wb, num, quo;
        r = '0;
        wa = a;
        wb = b;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: r.value = shr_wrap(wa * wb);
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    num = wa <<< FRAC;
                    quo = num / wb;
                    r.value = quo[31:0];
                end
            end
            OP_GT:  r.cmp = a > b;
            OP_LT:  r.cmp = a < b;
            OP_GE:  r.cmp = a >= b;
            OP_LE:  r.cmp = a <= b;
            OP_EQ:  r.cmp = a == b;
            OP_NE:  r.cmp = a != b;
            OP_MIN: r.value = (a < b) ? a : b;
            OP_MAX: r.value = (a > b) ? a : b;
            OP_INC: r.value = a + 32'sd1;
            OP_DEC: r.value = a - 32'sd1;
            OP_I2F: r.value = a <<< FRAC;
            default: r.value = shr_wrap(wa);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
                 result_count);
    endtask

    task automatic send_word(input t_op op, input logic signed [31:0] a,
                             input logic signed [31:0] b);
        in_if.valid     <= 1'b1;
        in_if.opcode    <= op;
        in_if.operand_a <= a;
        in_if.operand_b <= b;
        do @(posedge i_clk); while (!in_if.ready);
        expected_q.push_back(alu_predict(op, a, b));
        op_seen[op]++;
    endtask

    task automatic go_idle();
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        go_idle();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return $signed($urandom_range(0, 2047)) - 1024;
            default: return $urandom;
        endcase
    endfunction

    // receiver stall pattern plus the long hold-off
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_if.ready <= 1'b0;
                hold_cycles++;
            end else begin
                case (result_count / 200 % 3)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    default: out_if.ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_alu_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            result_count++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", out_if.result_value, 32'h0);
            end else begin
                want = expected_q.pop_front();
                if (out_if.result_value !== want.value)
                    report_mismatch("result_value", out_if.result_value, want.value);
                if (out_if.compare_true !== want.cmp)
                    report_mismatch("compare_true", out_if.compare_true, want.cmp);
                if (out_if.divide_by_zero !== want.dz)
                    report_mismatch("divide_by_zero", out_if.divide_by_zero, want.dz);
            end
        end
    end

    task automatic test_directed();
        logic signed [31:0] edges[6];
        edges = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd256, -32'sd256};
        for (int op = 0; op < 16; op++)
            send_word(t_op'(op), edges[op % 6], edges[(op + 1) % 6]);
        send_word(OP_DIV, 32'sd1000, 32'sd0);
        send_word(OP_DIV, 32'sh8000_0000, 32'sd0);
        send_word(OP_DIV, 32'sh8000_0000, -32'sd1);
        send_word(OP_DIV, -32'sd7, 32'sd2);
        send_word(OP_MUL, 32'sh8000_0000, 32'sh8000_0000);
        send_word(OP_MUL, -32'sd1, 32'sd1);
        send_word(OP_EQ, 32'sd5, 32'sd5);
        send_word(OP_INC, 32'sh7FFF_FFFF, 32'sd0);
        send_word(OP_DEC, 32'sh8000_0000, 32'sd0);
        wait_drained();
    endtask

    task automatic test_random(input int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < n; k++) begin
                // now and then use equal operands, and now and then a zero divisor for divide
                logic [31:0] a, b;
                t_op op;
                op = t_op'($urandom_range(0, 15));
                a = rand_operand();
                b = ($urandom_range(0, 9) == 0) ? a : rand_operand();
                if (op == OP_DIV && $urandom_range(0, 7) == 0) b = '0;
                send_word(op, a, b);
                sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                go_idle();
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                for (int k = 0; k < 120; k++)
                    send_word(t_op'($urandom_range(0, 15)), rand_operand(), rand_operand());
            end
            begin
                while (hold_cycles < 300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        wait_drained();
    endtask

    initial begin
        int waited;
        int fewest;
        in_if.valid     <= 1'b0;
        in_if.opcode    <= OP_ADD;
        in_if.operand_a <= '0;
        in_if.operand_b <= '0;
        hold_off = 1'b0;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(550);
        wait_drained();
        test_backpressure();
        test_random(550);
        go_idle();

        waited = 0;
        while (expected_q.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);

        fewest = op_seen[0];
        foreach (op_seen[k]) begin
            if (op_seen[k] < fewest) fewest = op_seen[k];
        end
        $display("covered %0d results over all 16 opcodes (fewest per opcode: %0d),",
                 result_count, fewest);
        $display("with operand extremes, zero divisors, bursty input and a long output stall");
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("PASS fixed_point_alu_q24_8_top");
        end else begin
            $display("FAIL fixed_point_alu_q24_8_top");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/fpa_pkg.sv
sv/fpa_if.sv
sv/fpa_div_step.sv
sv/fixed_point_alu_q24_8_top.sv
tb/fixed_point_alu_q24_8_top_tb.sv
